// File: sv/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_EMPTY    = 2'd1;
	localparam logic [1:0] KIND_BAD_SIZE = 2'd2;
	localparam logic [1:0] KIND_BAD_TYPE = 2'd3;

	localparam logic [7:0] CFG_MAX_PACKET_SIZE  = 8'd0;
	localparam logic [7:0] CFG_KNOWN_TYPE_COUNT = 8'd1;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] frame_type;
		logic [7:0]  payload_byte;
		logic        last_of_frame;
	} res_t;

	typedef struct packed {
		logic error_latched;
		logic in_payload;
		logic push;
	} front_status_t;

endpackage

// File: sv/lppd_front.sv
// ----------------------------------------------------------------------------
// lppd_front
// Header parser and classifier: assembles the four header bytes, checks size
// and type, tags payload bytes and writes a result to the queue for each payload byte and each empty or rejected frame.
// ----------------------------------------------------------------------------
module lppd_front import lppd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          cfg_valid,
	input  logic [7:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          queue_full,
	output res_t          push_data,
	output front_status_t status
);

	localparam logic [1:0] HDR_SIZE_LO = 2'd0;
	localparam logic [1:0] HDR_SIZE_HI = 2'd1;
	localparam logic [1:0] HDR_TYPE_LO = 2'd2;
	localparam logic [1:0] HDR_TYPE_HI = 2'd3;
	localparam logic [15:0] HDR_LEN = 16'(HEADER_BYTES);

	logic [15:0] max_size_q, type_count_q;
	logic [1:0]  hdr_pos_q, hdr_pos_d;
	logic        in_payload_q, in_payload_d;
	logic [7:0]  held_low_q, held_low_d;
	logic [15:0] frame_size_q, frame_size_d;
	logic [15:0] cur_type_q, cur_type_d;
	logic [15:0] remaining_q, remaining_d;
	logic        error_q, error_d;
	logic        accept, push;
	logic [15:0] new_type, rem_dec;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign new_type = {in_byte, held_low_q};
	assign rem_dec  = remaining_q - 16'd1;

	always_comb begin
		hdr_pos_d    = hdr_pos_q;
		in_payload_d = in_payload_q;
		held_low_d   = held_low_q;
		frame_size_d = frame_size_q;
		cur_type_d   = cur_type_q;
		remaining_d  = remaining_q;
		error_d      = error_q;
		push         = 1'b0;
		push_data    = '{result_kind: KIND_PAYLOAD, frame_type: cur_type_q,
			payload_byte: 8'd0, last_of_frame: 1'b0};
		if (accept && !error_q) begin
			if (in_payload_q) begin
				remaining_d = rem_dec;
				push = 1'b1;
				push_data.payload_byte  = in_byte;
				push_data.last_of_frame = (rem_dec == 16'd0);
				if (rem_dec == 16'd0) begin
					in_payload_d = 1'b0;
					hdr_pos_d    = HDR_SIZE_LO;
				end
			end else begin
				unique case (hdr_pos_q)
					HDR_SIZE_LO: begin
						held_low_d = in_byte;
						hdr_pos_d  = HDR_SIZE_HI;
					end
					HDR_SIZE_HI: begin
						frame_size_d = {in_byte, held_low_q};
						hdr_pos_d    = HDR_TYPE_LO;
					end
					HDR_TYPE_LO: begin
						held_low_d = in_byte;
						hdr_pos_d  = HDR_TYPE_HI;
					end
					HDR_TYPE_HI: begin
						cur_type_d = new_type;
						hdr_pos_d  = HDR_SIZE_LO;
						push_data.frame_type = new_type;
						// Size is checked before type, so a frame bad in both reports size.
						if (frame_size_q < HDR_LEN || frame_size_q > max_size_q) begin
							error_d = 1'b1;
							push    = 1'b1;
							push_data.result_kind = KIND_BAD_SIZE;
							push_data.frame_type  = frame_size_q;
						end else if (new_type >= type_count_q) begin
							error_d = 1'b1;
							push    = 1'b1;
							push_data.result_kind = KIND_BAD_TYPE;
						end else begin
							remaining_d = frame_size_q - HDR_LEN;
							if (frame_size_q == HDR_LEN) begin
								push = 1'b1;
								push_data.result_kind   = KIND_EMPTY;
								push_data.last_of_frame = 1'b1;
							end else begin
								in_payload_d = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q   <= 16'hFFFF;
			type_count_q <= 16'd256;
			hdr_pos_q    <= HDR_SIZE_LO;
			in_payload_q <= 1'b0;
			held_low_q   <= 8'd0;
			frame_size_q <= 16'd0;
			cur_type_q   <= 16'd0;
			remaining_q  <= 16'd0;
			error_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == CFG_MAX_PACKET_SIZE) begin
				max_size_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == CFG_KNOWN_TYPE_COUNT) begin
				type_count_q <= cfg_data;
			end
			hdr_pos_q    <= hdr_pos_d;
			in_payload_q <= in_payload_d;
			held_low_q   <= held_low_d;
			frame_size_q <= frame_size_d;
			cur_type_q   <= cur_type_d;
			remaining_q  <= remaining_d;
			error_q      <= error_d;
		end
	end

	assign status = '{error_latched: error_q, in_payload: in_payload_q, push: push};

endmodule

// File: sv/lppd_queue.sv
// ----------------------------------------------------------------------------
// lppd_queue
// Short first-in first-out queue of results between parser and output stage.
// ----------------------------------------------------------------------------
module lppd_queue import lppd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output res_t pop_data,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == FULL_CNT);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: sv/lppd_back.sv
// ----------------------------------------------------------------------------
// lppd_back
// Output stage: takes results from the queue into a register and presents
// them on the master stream.
// ----------------------------------------------------------------------------
module lppd_back import lppd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  res_t        q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] out_data,
	output logic [1:0]  out_user,
	output logic        out_last
);

	logic valid_q;
	res_t res_q;
	logic load;

	// The register refills in the same cycle that the downstream side takes it.
	assign load  = !valid_q || out_ready;
	assign q_pop = load && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= q_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {res_q.payload_byte, res_q.frame_type};
	assign out_user  = res_q.result_kind;
	assign out_last  = res_q.last_of_frame;

endmodule

// File: sv/length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Splits a byte stream into size/type framed packets and forwards payload.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the parser takes a byte whenever the result
// queue has room. A result reaches the master side by way of the queue write
// and then the output register.
// Reset clears parser state, queue and output register; registers return to
// max_packet_size 65535 and known_type_count 256.
module length_prefixed_packet_deframer import lppd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] frame_type, [23:16] payload_byte
	output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
	output logic        m_axis_tlast,   // last_of_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	res_t          push_data, pop_data;
	front_status_t status;
	logic          q_empty, q_full, q_pop;

	assign cfg_ready = 1'b1;

	lppd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (q_full),
		.push_data  (push_data),
		.status     (status)
	);

	lppd_queue #(.DEPTH(DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (status.push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	lppd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	// A result is only written for an accepted request.
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		status.push |-> (s_axis_tvalid && s_axis_tready))
		else $error("result written without an accepted request");

	// Once an error is reported, the parser writes no further results until reset.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.error_latched |=> (status.error_latched && !status.push))
		else $error("error latch released or result after error");

	// An error is only raised at a header check, so it never meets a payload run.
	a_error_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.error_latched && status.in_payload))
		else $error("payload run active while the error is latched");

	// Error results never carry the frame end marker.
	a_error_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == KIND_BAD_SIZE || m_axis_tuser == KIND_BAD_TYPE))
		|-> !m_axis_tlast)
		else $error("error result marked last");

	// An empty-frame result is always marked last.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_EMPTY) |-> m_axis_tlast)
		else $error("empty frame result not marked last");

endmodule
